@@ design/shfs_pkg.sv @@
// ----------------------------------------------------------------------------
// shfs_pkg
// Shared types and constants for the stepper half/full step controller.
// ----------------------------------------------------------------------------
package shfs_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd0;
  localparam logic [2:0] REG_PERIOD_NONE   = 3'd1;
  localparam logic [2:0] REG_PERIOD_FIRST  = 3'd2;
  localparam logic [2:0] REG_PERIOD_SECOND = 3'd3;
  localparam logic [2:0] REG_PERIOD_BOTH   = 3'd4;

  // Register reset values
  localparam logic [15:0] RST_SAMPLE_PERIOD = 16'd100;
  localparam logic [15:0] RST_PERIOD_NONE   = 16'd20;
  localparam logic [15:0] RST_PERIOD_FIRST  = 16'd40;
  localparam logic [15:0] RST_PERIOD_SECOND = 16'd30;
  localparam logic [15:0] RST_PERIOD_BOTH   = 16'd24;

  // Button combinations
  localparam logic [1:0] BTN_NONE   = 2'd0;
  localparam logic [1:0] BTN_FIRST  = 2'd1;
  localparam logic [1:0] BTN_SECOND = 2'd2;
  localparam logic [1:0] BTN_BOTH   = 2'd3;

  // One result item
  typedef struct packed {
    logic [3:0] coil_code;
    logic       stepped;
    logic [1:0] led_select;
    logic       sampled;
  } result_t;

  // Coil drive pattern for each of the eight phase positions
  function automatic logic [3:0] coil_lookup(input logic [2:0] ph);
    logic [3:0] code;
    case (ph)
      3'd0:    code = 4'hA;
      3'd1:    code = 4'h8;
      3'd2:    code = 4'h9;
      3'd3:    code = 4'h1;
      3'd4:    code = 4'h5;
      3'd5:    code = 4'h4;
      3'd6:    code = 4'h6;
      3'd7:    code = 4'h2;
      default: code = 4'hA;
    endcase
    return code;
  endfunction

endpackage

@@ design/stepper_half_full_step_controller_core.sv @@
// ----------------------------------------------------------------------------
// stepper_half_full_step_controller_core
// Half/full step phase sequencer for a unipolar stepper, one tick per item.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one tick carrying the two button
// levels; each tick yields exactly one result with the coil code, a step
// flag, the mode LED selection and a sample flag. A tick is processed in the
// cycle it is accepted: the counters decrement, button decode and phase
// update are a single pass of logic into the output register, so one tick per
// cycle is sustained while the output is not stalled. A skid register behind
// the output register lets one more tick in while a result is stalled; input
// stall rises only once both are full. Period registers are written through
// the configuration port and take effect at the next reload or decode.
module stepper_half_full_step_controller_core (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  buttons,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  coil_code,
  output logic        stepped,
  output logic [1:0]  led_select,
  output logic        sampled,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers
  logic [15:0] sample_period;
  logic [15:0] period_none;
  logic [15:0] period_first;
  logic [15:0] period_second;
  logic [15:0] period_both;

  // Sequencer state
  logic [2:0]  phase;
  logic        counter_clockwise;
  logic        half_mode;
  logic [15:0] step_period;
  logic [15:0] sample_count;
  logic [15:0] step_count;
  logic [1:0]  led_state;

  // Next state
  logic [2:0]  phase_next;
  logic        counter_clockwise_next;
  logic        half_mode_next;
  logic [15:0] step_period_next;
  logic [15:0] sample_count_next;
  logic [15:0] step_count_next;
  logic [1:0]  led_state_next;

  logic [15:0] sample_dec;
  logic [15:0] step_dec;
  logic        do_sample;
  logic        do_step;
  logic [15:0] period_sel;
  logic [2:0]  amount;

  shfs_pkg::result_t result;
  shfs_pkg::result_t out_reg;
  shfs_pkg::result_t skid;
  logic              skid_valid;
  logic              in_take;
  logic              out_take;

  // Handshake
  assign in_stall = skid_valid;
  assign in_take  = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  // Write configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= shfs_pkg::RST_SAMPLE_PERIOD;
      period_none   <= shfs_pkg::RST_PERIOD_NONE;
      period_first  <= shfs_pkg::RST_PERIOD_FIRST;
      period_second <= shfs_pkg::RST_PERIOD_SECOND;
      period_both   <= shfs_pkg::RST_PERIOD_BOTH;
    end else if (cfg_we) begin
      case (cfg_index)
        shfs_pkg::REG_SAMPLE_PERIOD: sample_period <= cfg_data;
        shfs_pkg::REG_PERIOD_NONE:   period_none   <= cfg_data;
        shfs_pkg::REG_PERIOD_FIRST:  period_first  <= cfg_data;
        shfs_pkg::REG_PERIOD_SECOND: period_second <= cfg_data;
        shfs_pkg::REG_PERIOD_BOTH:   period_both   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Select the step period for the sampled buttons
  always_comb begin
    case (buttons)
      shfs_pkg::BTN_NONE:   period_sel = period_none;
      shfs_pkg::BTN_FIRST:  period_sel = period_first;
      shfs_pkg::BTN_SECOND: period_sel = period_second;
      shfs_pkg::BTN_BOTH:   period_sel = period_both;
      default:              period_sel = period_none;
    endcase
  end

  // Process one tick: decrement counters, decode buttons, advance phase
  always_comb begin
    sample_dec = sample_count - 16'd1;
    step_dec   = step_count - 16'd1;
    do_sample  = (sample_dec == 16'd0);
    do_step    = (step_dec == 16'd0);

    counter_clockwise_next = counter_clockwise;
    half_mode_next         = half_mode;
    step_period_next       = step_period;
    led_state_next         = led_state;
    sample_count_next      = sample_dec;
    if (do_sample) begin
      counter_clockwise_next = buttons[1];
      half_mode_next         = !buttons[0];
      step_period_next       = period_sel;
      led_state_next         = buttons;
      sample_count_next      = sample_period;
    end

    amount          = half_mode_next ? 3'd1 : 3'd2;
    phase_next      = phase;
    step_count_next = step_dec;
    if (do_step) begin
      phase_next      = counter_clockwise_next ? (phase - amount) : (phase + amount);
      step_count_next = step_period_next;
    end

    result.coil_code  = shfs_pkg::coil_lookup(phase_next);
    result.stepped    = do_step;
    result.led_select = led_state_next;
    result.sampled    = do_sample;
  end

  // Update state on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= 3'd0;
      counter_clockwise <= 1'b0;
      half_mode         <= 1'b1;
      step_period       <= shfs_pkg::RST_PERIOD_NONE;
      sample_count      <= shfs_pkg::RST_SAMPLE_PERIOD;
      step_count        <= shfs_pkg::RST_PERIOD_NONE;
      led_state         <= 2'd0;
    end else if (in_take) begin
      phase             <= phase_next;
      counter_clockwise <= counter_clockwise_next;
      half_mode         <= half_mode_next;
      step_period       <= step_period_next;
      sample_count      <= sample_count_next;
      step_count        <= step_count_next;
      led_state         <= led_state_next;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_take;
      end
    end else if (in_take) begin
      skid_valid <= 1'b1;
    end
  end

  // Move payload; hold while stalled
  always_ff @(posedge clk) begin
    if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_reg <= skid;
      end else if (in_take) begin
        out_reg <= result;
      end
    end else if (in_take) begin
      skid <= result;
    end
  end

  assign coil_code  = out_reg.coil_code;
  assign stepped    = out_reg.stepped;
  assign led_select = out_reg.led_select;
  assign sampled    = out_reg.sampled;

endmodule
